@@ rtl/sud_pkg.sv @@
// Shared types and constants for the pipelined divider.
`default_nettype none
package sud_pkg;

	// Width of the data ports, fixed by the interface.
	localparam int FIELD_W = 64;

	// Division modes carried on func.
	localparam logic FUNC_UNSIGNED = 1'b0;
	localparam logic FUNC_SIGNED   = 1'b1;

	// Control that travels down the pipe with each beat.
	typedef struct packed {
		logic valid;
		logic neg_q;  // negate the quotient at the end
		logic neg_r;  // negate the remainder at the end
		logic dzero;  // divisor was zero
	} ctl_t;

endpackage
`default_nettype wire

@@ rtl/sud_prep.sv @@
// Entry stage: operand magnitudes, sign flags and zero-divisor detect.
`default_nettype none
module sud_prep #(
	parameter int W = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               accept,
	input  wire               func,
	input  wire  [W-1:0]      dividend,
	input  wire  [W-1:0]      divisor,
	output sud_pkg::ctl_t     ctl_s1,
	output logic [W-1:0]      nq_s1,
	output logic [W-1:0]      den_s1
);

	logic         is_signed;
	logic         neg_n;
	logic         neg_d;
	logic [W-1:0] mag_n;
	logic [W-1:0] mag_d;
	logic         valid_s1;
	logic         neg_q_s1;
	logic         neg_r_s1;
	logic         dzero_s1;

	assign is_signed = (func == sud_pkg::FUNC_SIGNED);
	assign neg_n     = is_signed & dividend[W-1];
	assign neg_d     = is_signed & divisor[W-1];
	assign mag_n     = neg_n ? (~dividend + W'(1)) : dividend;
	assign mag_d     = neg_d ? (~divisor + W'(1)) : divisor;

	// member order: valid, neg_q, neg_r, dzero
	assign ctl_s1 = {valid_s1, neg_q_s1, neg_r_s1, dzero_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		neg_q_s1 <= neg_n ^ neg_d;
		neg_r_s1 <= neg_n;
		dzero_s1 <= (divisor == '0);
		nq_s1    <= mag_n;
		den_s1   <= mag_d;
	end

endmodule
`default_nettype wire

@@ rtl/sud_step.sv @@
// One restoring-division step: shift in a dividend bit, trial subtract, keep or restore.
`default_nettype none
module sud_step #(
	parameter int W = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  sud_pkg::ctl_t     ctl_in,
	input  wire  [W-1:0]      rem_in,
	input  wire  [W-1:0]      nq_in,
	input  wire  [W-1:0]      den_in,
	output sud_pkg::ctl_t     ctl_s2,
	output logic [W-1:0]      rem_s2,
	output logic [W-1:0]      nq_s2,
	output logic [W-1:0]      den_s2
);

	logic         carry;
	logic [W-1:0] shifted;
	logic [W+1:0] diff;
	logic         take;
	logic         valid_s2;
	logic         neg_q_s2;
	logic         neg_r_s2;
	logic         dzero_s2;

	// nq holds unconsumed dividend bits on top and quotient bits on the bottom
	assign carry   = rem_in[W-1];
	assign shifted = {rem_in[W-2:0], nq_in[W-1]};
	assign diff    = {1'b0, carry, shifted} - {2'b00, den_in};
	assign take    = ~diff[W+1];

	// member order: valid, neg_q, neg_r, dzero
	assign ctl_s2 = {valid_s2, neg_q_s2, neg_r_s2, dzero_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		neg_q_s2 <= ctl_in.neg_q;
		neg_r_s2 <= ctl_in.neg_r;
		dzero_s2 <= ctl_in.dzero;
		rem_s2   <= take ? diff[W-1:0] : shifted;
		nq_s2    <= {nq_in[W-2:0], take};
		den_s2   <= den_in;
	end

endmodule
`default_nettype wire

@@ rtl/sud_post.sv @@
// Exit stage: zero-divisor fixup and sign restore of quotient and remainder.
`default_nettype none
module sud_post #(
	parameter int W = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  sud_pkg::ctl_t     ctl_in,
	input  wire  [W-1:0]      rem_in,
	input  wire  [W-1:0]      quo_in,
	output logic              strobe_s3,
	output logic [W-1:0]      quo_s3,
	output logic [W-1:0]      rem_s3
);

	logic [W-1:0] q_mag;
	logic [W-1:0] r_mag;

	// With a zero divisor every step subtracts nothing, so the remainder
	// register ends up holding the dividend magnitude.
	assign q_mag = ctl_in.dzero ? rem_in : quo_in;
	assign r_mag = ctl_in.dzero ? '0 : rem_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s3 <= 1'b0;
		end else begin
			strobe_s3 <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		quo_s3 <= ctl_in.neg_q ? (~q_mag + W'(1)) : q_mag;
		rem_s3 <= ctl_in.neg_r ? (~r_mag + W'(1)) : r_mag;
	end

endmodule
`default_nettype wire

@@ rtl/signed_unsigned_divider_64_top.sv @@
// Top level of the fully pipelined signed/unsigned restoring divider.
//  - Input channel: a beat (func, dividend, divisor) is taken at every rising
//    edge where start is high and busy is low. busy is tied low: the pipe
//    takes a new beat every cycle, back to back, with no gaps.
//  - func = 0 divides unsigned, func = 1 divides two's complement signed;
//    the quotient truncates toward zero, the remainder has the dividend's sign.
//  - Divide by zero returns quotient = dividend, remainder = 0 in both modes.
//    Minimum value divided by minus one wraps to the minimum value.
//  - Output channel: quotient and remainder are presented for exactly one
//    cycle with strobe high. There is no backpressure; the receiver must
//    take the beat in that cycle.
//  - Pipeline: a beat passes through one entry stage, DATA_WIDTH division steps
//    and one exit stage. Throughput is one division per cycle; each bit of the
//    quotient has a register stage of its own with one DATA_WIDTH+2 bit
//    subtractor, which sets the clock period.
//  - Only the low DATA_WIDTH bits of the operands are used; the upper bits
//    of the results are zero.
//  - Reset (arst_n low) clears all valid bits at once; beats in flight are
//    dropped and no strobe appears until new beats arrive.
`default_nettype none
module signed_unsigned_divider_64_top #(
	parameter int DATA_WIDTH = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         func,
	input  wire  [63:0] dividend,
	input  wire  [63:0] divisor,
	output logic        strobe,
	output logic [63:0] quotient,
	output logic [63:0] remainder
);

	localparam int FW  = sud_pkg::FIELD_W;
	localparam int W   = DATA_WIDTH;
	localparam int LAT = DATA_WIDTH + 2;

	logic accept;

	// Stage i feeds step i; index W is the output of the last step.
	sud_pkg::ctl_t ctl_a [0:W];
	logic [W-1:0]  rem_a [0:W];
	logic [W-1:0]  nq_a  [0:W];
	logic [W-1:0]  den_a [0:W];

	logic         strobe_w;
	logic [W-1:0] quo_w;
	logic [W-1:0] rem_w;

	// Pipe never stalls, so it can always take a beat.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	sud_prep #(.W(W)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (func),
		.dividend (dividend[W-1:0]),
		.divisor  (divisor[W-1:0]),
		.ctl_s1   (ctl_a[0]),
		.nq_s1    (nq_a[0]),
		.den_s1   (den_a[0])
	);

	// Partial remainder starts at zero for every beat.
	assign rem_a[0] = '0;

	for (genvar i = 0; i < W; i++) begin : g_step
		sud_step #(.W(W)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_a[i]),
			.rem_in (rem_a[i]),
			.nq_in  (nq_a[i]),
			.den_in (den_a[i]),
			.ctl_s2 (ctl_a[i+1]),
			.rem_s2 (rem_a[i+1]),
			.nq_s2  (nq_a[i+1]),
			.den_s2 (den_a[i+1])
		);
	end

	// den_a[W] is not needed past the last step; the quotient sits in nq_a[W].
	sud_post #(.W(W)) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_a[W]),
		.rem_in    (rem_a[W]),
		.quo_in    (nq_a[W]),
		.strobe_s3 (strobe_w),
		.quo_s3    (quo_w),
		.rem_s3    (rem_w)
	);

	assign strobe    = strobe_w;
	assign quotient  = FW'(quo_w);
	assign remainder = FW'(rem_w);

`ifndef SYNTH
	// A result beat only comes out of an accepted input beat.
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(accept, LAT))
		else $error("strobe without matching accepted beat");

	// Divide by zero leaves a zero remainder.
	a_dzero_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && $past(accept && (divisor[W-1:0] == '0), LAT))
		|-> (remainder == '0))
		else $error("nonzero remainder on divide by zero");

	// Unsigned remainder is below the divisor.
	a_urem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && $past(accept && (func == sud_pkg::FUNC_UNSIGNED)
			&& (divisor[W-1:0] != '0), LAT))
		|-> (remainder[W-1:0] < $past(divisor[W-1:0], LAT)))
		else $error("unsigned remainder not below divisor");

	// Signed remainder of a nonnegative dividend is nonnegative.
	a_srem_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && $past(accept && (func == sud_pkg::FUNC_SIGNED)
			&& !dividend[W-1], LAT))
		|-> !remainder[W-1])
		else $error("remainder sign differs from dividend");
`endif

endmodule
`default_nettype wire
